// ===== hdl/mte_pkg.sv =====
// Shared constants, types and the sine table for the modulated tape echo.
// Depends on nothing; every other file imports it.
`default_nettype none
package mte_pkg;
  localparam int RING_FRAMES  = 65536;
  localparam int RING_BITS    = $clog2(RING_FRAMES);
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int PHASE_BITS   = 24;
  localparam int POS_BITS     = RING_BITS + 8;
  localparam int DLY_W        = (POS_BITS > 27) ? POS_BITS : 27;
  localparam int SAMPLE_W     = 16;
  localparam int RING_W       = 18;
  localparam int WORD_W       = 2 * RING_W;
  localparam int QUO_BITS     = 20;
  localparam int NUM_W        = 41;
  localparam int DEN_W        = 26;
  localparam int SH_W         = DEN_W + QUO_BITS - 1;
  localparam int CNT_W        = $clog2(QUO_BITS + 1);

  localparam logic [30:0] SWING_M  = 31'd1832519380;
  localparam int          SWING_SH = 37;
  localparam logic [25:0] DIV100_M = 26'd42949673;
  localparam logic [25:0] SOFT_DEN = 26'd3276800;

  typedef enum logic [2:0] {
    REG_ENABLE, REG_BASE, REG_STEP, REG_DEPTH, REG_FEEDBACK, REG_MIX, REG_SAT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SWING, S_MOD, S_POS, S_RD0, S_RD1, S_INT0, S_INT1,
    S_GAIN, S_SCALE, S_SOFT, S_DIV, S_WB
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  function automatic logic signed [15:0] quarter_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((p * x2) >> 30);
    p  = 64'd85569306 - ((p * x2) >> 30);
    p  = 64'd693598669 - ((p * x2) >> 30);
    p  = 64'd1686629713 - ((p * x2) >> 30);
    r  = (p * x) >> 30;
    r  = (r + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return $signed(r[15:0]);
  endfunction

  function automatic sine_tab_t make_sine();
    sine_tab_t t;
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] r;
    logic signed [15:0] s;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      q4   = 64'(k) * 64'd4;
      quad = q4 / SINE_ENTRIES;
      r    = q4 % SINE_ENTRIES;
      if (quad[0]) r = 64'(SINE_ENTRIES) - r;
      s    = quarter_sine((r << 30) / SINE_ENTRIES);
      t[k] = (quad >= 64'd2) ? -s : s;
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = make_sine();
endpackage
`default_nettype wire

// ===== hdl/modulated_tape_echo_top.sv =====
// Stereo feedback echo with a sine-modulated, interpolated delay read.
// Depends on mte_pkg, mte_ring_ram and mte_div.
//
// One frame is taken while the sequencer is idle. Its result is loaded into
// the output register in the write-back step, after the swing, modulation,
// position, ring read, interpolation, gain, scale and soft-clip steps, and
// the next frame can be taken in the cycle after the load. With soft clipping
// enabled the feedback divider step lies between the soft-clip and write-back
// steps. A result that waits in the output register holds the sequencer in
// its write-back step. The frame time is set by the two reads of the single
// ring read port and the multiply and divide steps that follow them. The ring
// needs no clearing after reset: frames are written in order, so an entry not
// written since reset reads as zero by comparing against the write pointer.
`default_nettype none
module modulated_tape_echo_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_left,
  input  wire logic [15:0] in_right,
  input  wire logic        in_frame_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_left,
  output logic      [15:0] out_right,
  output logic             out_block_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import mte_pkg::*;

  state_t state_r, state_nxt;

  logic                  en_r;
  logic [14:0]           base_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [10:0]           depth_r;
  logic [6:0]            fbp_r, mixp_r, satp_r;

  logic [RING_BITS-1:0]  wf_r;
  logic                  wrap_r;
  logic [PHASE_BITS-1:0] phase_r;

  logic signed [SAMPLE_W-1:0] x_r [2];
  logic                       last_r;
  logic [25:0]                prod_r;
  logic signed [15:0]         sine_r;
  logic [23:0]                swing_r;
  logic signed [40:0]         ss_r;
  logic [POS_BITS-1:0]        pos_r;
  logic                       v0_r, v1_r;
  logic signed [27:0]         p0_r [2];
  logic signed [28:0]         acc_r [2];
  logic signed [RING_W-1:0]   d_r [2];
  logic signed [25:0]         fbraw_r [2];
  logic signed [25:0]         mxraw_r [2];
  logic signed [18:0]         fb_r [2];
  logic signed [16:0]         o_r [2];
  logic signed [20:0]         fbf_r [2];

  logic                 out_valid_r;
  logic [15:0]          out_left_r, out_right_r;
  logic                 out_last_r;

  logic                 out_load, ram_re, ram_we, div_start;
  logic [RING_BITS-1:0] raddr, i0;
  logic [WORD_W-1:0]    rdata, wdata;
  logic signed [RING_W-1:0] ring_ch [2];
  logic [60:0]          sw_prod;
  logic signed [25:0]   ssq;
  logic signed [DLY_W-1:0] delay;
  logic [7:0]           frac;
  logic [7:0]           sf;
  logic [17:0]          mag [2];
  logic [NUM_W-1:0]     num [2];
  logic [DEN_W-1:0]     den [2];
  div_stat_t            div_stat [2];
  logic [QUO_BITS-1:0]  quo [2];
  logic signed [RING_W-1:0]   store [2];
  logic signed [SAMPLE_W-1:0] y [2];

  function automatic logic signed [18:0] tdiv100(logic signed [25:0] v);
    logic [24:0] m;
    logic [50:0] p;
    logic [18:0] q;
    m = v[25] ? 25'(-v) : v[24:0];
    p = 51'(m) * 51'(DIV100_M);
    q = p[50:32];
    return v[25] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [RING_W-1:0] sat_ring(logic signed [21:0] v);
    if (v > 22'sd131071) return 18'sd131071;
    if (v < -22'sd131072) return -18'sd131072;
    return v[RING_W-1:0];
  endfunction

  function automatic logic signed [16:0] clip_out(logic signed [19:0] v);
    if (v > 20'sd32768) return 17'sd32768;
    if (v < -20'sd32768) return -17'sd32768;
    return v[16:0];
  endfunction

  function automatic logic signed [15:0] scale_out(logic signed [16:0] v);
    logic signed [33:0] p;
    logic signed [33:0] b;
    p = 34'(v) * 34'sd32767;
    b = p + (p[33] ? 34'sd32767 : 34'sd0);
    return 16'(b >>> 15);
  endfunction

  // Configuration.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      base_r  <= 15'd11025;
      step_r  <= '0;
      depth_r <= '0;
      fbp_r   <= '0;
      mixp_r  <= '0;
      satp_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:   en_r    <= cfg_data[0];
        REG_BASE:     base_r  <= cfg_data[14:0];
        REG_STEP:     step_r  <= cfg_data[PHASE_BITS-1:0];
        REG_DEPTH:    depth_r <= cfg_data[10:0];
        REG_FEEDBACK: fbp_r   <= cfg_data[6:0];
        REG_MIX:      mixp_r  <= cfg_data[6:0];
        REG_SAT:      satp_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SWING;
      S_SWING: state_nxt = S_MOD;
      S_MOD:   state_nxt = S_POS;
      S_POS:   state_nxt = S_RD0;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_INT0;
      S_INT0:  state_nxt = S_INT1;
      S_INT1:  state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_SOFT;
      S_SOFT:  state_nxt = (satp_r != '0) ? S_DIV : S_WB;
      S_DIV:   if (div_stat[0].done) state_nxt = S_WB;
      S_WB:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign i0 = pos_r[POS_BITS-1:8];

  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    raddr     = i0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_RD0:  ram_re = 1'b1;
      S_RD1: begin
        ram_re = 1'b1;
        raddr  = i0 + 1'b1;
      end
      S_SOFT: div_start = satp_r != '0;
      S_WB:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign ram_we = out_load;

  // Datapath.
  assign sw_prod = 61'({prod_r, 4'd0}) * 61'(SWING_M);
  assign ssq     = 26'((ss_r + (ss_r[40] ? 41'sd32767 : 41'sd0)) >>> 15);
  assign delay   = $signed(DLY_W'({base_r, 8'd0})) + DLY_W'(ssq);
  assign frac    = pos_r[7:0];
  assign sf      = {satp_r, 1'b0};
  assign ring_ch[0] = $signed(rdata[WORD_W-1:RING_W]);
  assign ring_ch[1] = $signed(rdata[RING_W-1:0]);

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      mag[ch] = fb_r[ch][18] ? 18'(-fb_r[ch]) : fb_r[ch][17:0];
      num[ch] = NUM_W'(26'(mag[ch]) * 26'(9'd100 + 9'(sf))) << 15;
      den[ch] = SOFT_DEN + 26'(26'(mag[ch]) * 26'(sf));
      if (en_r) begin
        store[ch] = sat_ring(22'(x_r[ch]) + 22'(fbf_r[ch]));
        y[ch]     = scale_out(o_r[ch]);
      end else begin
        store[ch] = RING_W'(x_r[ch]);
        y[ch]     = x_r[ch];
      end
    end
  end

  assign wdata = {store[0], store[1]};

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r[0] <= $signed(in_left);
        x_r[1] <= $signed(in_right);
        last_r <= in_frame_last;
        prod_r <= 26'(base_r) * 26'(depth_r);
        sine_r <= SINE_TAB[phase_r[PHASE_BITS-1 -: SINE_BITS]];
      end
      S_SWING: swing_r <= sw_prod[60:SWING_SH];
      S_MOD:   ss_r <= $signed({1'b0, swing_r}) * sine_r;
      S_POS:   pos_r <= {wf_r, 8'd0} - POS_BITS'(delay);
      S_RD0:   v0_r <= wrap_r || (i0 < wf_r);
      S_RD1: begin
        v1_r <= wrap_r || (raddr < wf_r);
        for (int ch = 0; ch < 2; ch++) begin
          p0_r[ch] <= (v0_r ? ring_ch[ch] : $signed(RING_W'(0))) *
                      $signed({1'b0, 9'd256 - 9'(frac)});
        end
      end
      S_INT0: begin
        for (int ch = 0; ch < 2; ch++) begin
          acc_r[ch] <= 29'(p0_r[ch]) +
                       (29'(v1_r ? ring_ch[ch] : $signed(RING_W'(0))) *
                        $signed({2'b0, frac}));
        end
      end
      S_INT1: begin
        for (int ch = 0; ch < 2; ch++) begin
          d_r[ch] <= RING_W'((acc_r[ch] + (acc_r[ch][28] ? 29'sd255 : 29'sd0)) >>> 8);
        end
      end
      S_GAIN: begin
        for (int ch = 0; ch < 2; ch++) begin
          fbraw_r[ch] <= d_r[ch] * $signed({1'b0, fbp_r});
          mxraw_r[ch] <= d_r[ch] * $signed({1'b0, mixp_r});
        end
      end
      S_SCALE: begin
        for (int ch = 0; ch < 2; ch++) begin
          fb_r[ch] <= tdiv100(fbraw_r[ch]);
          o_r[ch]  <= clip_out(20'(x_r[ch]) + 20'(tdiv100(mxraw_r[ch])));
        end
      end
      S_SOFT: begin
        for (int ch = 0; ch < 2; ch++) fbf_r[ch] <= 21'(fb_r[ch]);
      end
      S_DIV: begin
        if (div_stat[0].done) begin
          for (int ch = 0; ch < 2; ch++) begin
            fbf_r[ch] <= fb_r[ch][18] ? -$signed({1'b0, quo[ch]}) : $signed({1'b0, quo[ch]});
          end
        end
      end
      default: ;
    endcase
  end

  // Ring pointer, fill mark and LFO.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wf_r    <= '0;
      wrap_r  <= 1'b0;
      phase_r <= '0;
    end else if (out_load) begin
      wf_r    <= wf_r + 1'b1;
      phase_r <= phase_r + step_r;
      if (&wf_r) wrap_r <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= y[0];
      out_right_r <= y[1];
      out_last_r  <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left       = out_left_r;
  assign out_right      = out_right_r;
  assign out_block_last = out_last_r;

  mte_ring_ram u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wf_r),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  for (genvar g = 0; g < 2; g++) begin : g_div
    mte_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (num[g]),
      .den   (den[g]),
      .stat  (div_stat[g]),
      .quo   (quo[g])
    );
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_valid |=> state_r == S_SWING)
    else $error("accepted word did not start the sequence");
  a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> wf_r == RING_BITS'($past(wf_r) + 1'b1))
    else $error("write pointer did not advance after a ring write");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_valid_r)
    else $error("ring write without a result word");
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_stat[0].busy && state_r == S_DIV)
    else $error("divider not busy after start");
`endif
endmodule
`default_nettype wire

// ===== hdl/mte_ring_ram.sv =====
// Frame ring memory: one write port and one registered read port.
// Depends on mte_pkg for depth and word width.
`default_nettype none
module mte_ring_ram (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [mte_pkg::RING_BITS-1:0] waddr,
  input  wire logic [mte_pkg::WORD_W-1:0]    wdata,
  input  wire logic                          re,
  input  wire logic [mte_pkg::RING_BITS-1:0] raddr,
  output logic      [mte_pkg::WORD_W-1:0]    rdata
);
  import mte_pkg::*;

  logic [WORD_W-1:0] mem [RING_FRAMES];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hdl/mte_div.sv =====
// Restoring divider for the soft clip, one quotient bit per cycle.
// Depends on mte_pkg for operand widths and the status struct.
`default_nettype none
module mte_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mte_pkg::NUM_W-1:0]    num,
  input  wire logic [mte_pkg::DEN_W-1:0]    den,
  output mte_pkg::div_stat_t                stat,
  output logic      [mte_pkg::QUO_BITS-1:0] quo
);
  import mte_pkg::*;

  logic [SH_W-1:0]     rem_r, rem_nxt;
  logic [SH_W-1:0]     dsh_r;
  logic [QUO_BITS-1:0] quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r, done_r;
  logic                take;

  assign take    = rem_r >= dsh_r;
  assign rem_nxt = take ? rem_r - dsh_r : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SH_W'(num);
      dsh_r <= {den, {(QUO_BITS-1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUO_BITS-2:0], take};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
endmodule
`default_nettype wire
